>>> hw/rtl/pixel_neighbour_count_detector_assert.svh
// assertion macros for the rtl
`ifndef PIXEL_NEIGHBOUR_COUNT_DETECTOR_ASSERT_SVH
`define PIXEL_NEIGHBOUR_COUNT_DETECTOR_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

>>> hw/rtl/pnc_pkg.sv
package pnc_pkg;

  localparam int MAX_WIDTH = 512;
  localparam int LS_AW     = $clog2(MAX_WIDTH);
  localparam int COL_W     = 9;
  localparam int SIDE_W    = 10;
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 24;
  localparam int THR_W     = 4;
  localparam int CNT_W     = 4;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 4;
  localparam int MAX_RES   = 3;

  localparam int FIFO_AW    = 3;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  localparam logic [SIDE_W-1:0]  RST_RADAR_WIDTH = SIDE_W'(512);
  localparam logic [COLOR_W-1:0] RST_CLASS_A     = 24'h5252D6;
  localparam logic [COLOR_W-1:0] RST_CLASS_B     = 24'hFF394A;
  localparam logic [THR_W-1:0]   RST_MIN_NB      = 4'd3;

  localparam logic [SIDE_W-1:0] MIN_SIDE = SIDE_W'(3);
  localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(MAX_WIDTH);

  // window bit map: row above in bits 2:0, centre row 5:3, newest row 8:6,
  // higher bit is the column further right
  localparam logic [8:0] WIN_KEEP    = 9'h0DB;
  localparam logic [8:0] CENTRE_MASK = 9'h1EF;
  localparam logic [8:0] BOTTOM_MASK = 9'h178;

  typedef enum logic [1:0] {
    REG_RADAR_WIDTH = 2'd0,
    REG_CLASS_A     = 2'd1,
    REG_CLASS_B     = 2'd2,
    REG_MIN_NB      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic             cls;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
    logic             bottom;
    logic             last_col;
  } s1_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] row;
    logic             frame_end;
    logic             none_found;
  } res_t;

  typedef struct packed {
    logic [1:0]              n;
    res_t [MAX_RES-1:0]      res;
  } push_t;

  function automatic logic [CNT_W-1:0] popcount9(input logic [8:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

>>> hw/rtl/pnc_if.sv
interface pnc_pix_if;
  logic                     valid;
  logic                     ready;
  logic [pnc_pkg::CH_W-1:0] red;
  logic [pnc_pkg::CH_W-1:0] green;
  logic [pnc_pkg::CH_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface pnc_res_if;
  logic                      valid;
  logic                      ready;
  logic [pnc_pkg::COL_W-1:0] col;
  logic [pnc_pkg::COL_W-1:0] row;
  logic                      frame_end;
  logic                      none_found;

  modport source (output valid, output col, output row, output frame_end,
                  output none_found, input ready);
  modport sink (input valid, input col, input row, input frame_end,
                input none_found, output ready);
endinterface

>>> hw/rtl/pnc_ram.sv
module pnc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pnc_window.sv
module pnc_window (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             s1_valid,
  input  pnc_pkg::s1_t                     s1,
  input  logic [1:0]                       ls_rdata,
  input  logic [pnc_pkg::THR_W-1:0]        min_nb,
  output logic                             ls_we,
  output logic [pnc_pkg::LS_AW-1:0]        ls_waddr,
  output logic [1:0]                       ls_wdata,
  output pnc_pkg::push_t                   push
);

  logic [8:0] win_r, win_nxt;
  logic       found_r, found_nxt;
  logic       top, mid;
  logic       hit_c, hit_b, is_end, found_now;
  logic [1:0] n;
  pnc_pkg::res_t [pnc_pkg::MAX_RES-1:0] res;

  assign top = ls_rdata[1];
  assign mid = ls_rdata[0];

  // new column enters on the right, oldest drops off the left
  assign win_nxt = ((win_r >> 1) & pnc_pkg::WIN_KEEP) |
                   {s1.cls, 2'b00, mid, 2'b00, top, 2'b00};

  assign ls_we    = s1_valid;
  assign ls_waddr = pnc_pkg::LS_AW'(s1.col);
  assign ls_wdata = {mid, s1.cls};

  assign hit_c = (s1.row >= pnc_pkg::COL_W'(2)) && (s1.col >= pnc_pkg::COL_W'(2)) &&
                 win_nxt[4] &&
                 (pnc_pkg::popcount9(win_nxt & pnc_pkg::CENTRE_MASK) >= min_nb);
  assign hit_b = s1.bottom && (s1.col >= pnc_pkg::COL_W'(2)) && win_nxt[7] &&
                 (pnc_pkg::popcount9(win_nxt & pnc_pkg::BOTTOM_MASK) >= min_nb);
  assign is_end    = s1.bottom && s1.last_col;
  assign found_now = found_r | hit_c | hit_b;

  always_comb begin
    res = '0;
    n   = '0;
    if (hit_c) begin
      res[n] = '{col: s1.col - pnc_pkg::COL_W'(1), row: s1.row - pnc_pkg::COL_W'(1),
                 frame_end: 1'b0, none_found: 1'b0};
      n = n + 2'd1;
    end
    if (hit_b) begin
      res[n] = '{col: s1.col - pnc_pkg::COL_W'(1), row: s1.row,
                 frame_end: 1'b0, none_found: 1'b0};
      n = n + 2'd1;
    end
    if (is_end) begin
      res[n] = '{col: '0, row: '0, frame_end: 1'b1, none_found: !found_now};
      n = n + 2'd1;
    end
    push.res = res;
    push.n   = s1_valid ? n : 2'd0;
  end

  assign found_nxt = is_end ? 1'b0 : found_now;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      found_r <= 1'b0;
    end else if (s1_valid) begin
      win_r   <= win_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

>>> hw/rtl/pnc_fifo.sv
module pnc_fifo (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pnc_pkg::push_t             push,
  input  logic                       pop,
  output logic                       head_valid,
  output pnc_pkg::res_t              head,
  output logic [pnc_pkg::FIFO_AW:0]  level
);

  pnc_pkg::res_t mem_r [pnc_pkg::FIFO_DEPTH];
  logic [pnc_pkg::FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [pnc_pkg::FIFO_AW:0]   count_r;

  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign level      = count_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < pnc_pkg::MAX_RES; k++) begin
      if (k < int'(push.n)) begin
        mem_r[wr_ptr_r + pnc_pkg::FIFO_AW'(k)] <= push.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + pnc_pkg::FIFO_AW'(push.n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + pnc_pkg::FIFO_AW'(1);
      end
      count_r <= count_r + (pnc_pkg::FIFO_AW+1)'(push.n) -
                 (pnc_pkg::FIFO_AW+1)'(pop);
    end
  end

endmodule

>>> hw/rtl/pixel_neighbour_count_detector.sv
// channel  dir  payload                              handshake
// in_ch    in   red, green, blue (8 bits each)       valid/ready
// out_ch   out  col, row, frame_end, none_found      valid/ready
// apb      in   psel penable pwrite paddr pwdata     pready always high
//
// one pixel per clock unless the input stalls; a result passes the s1 register and the result queue
// the registered line store read sets the two-stage read-modify-write pipeline
// an eight-entry result queue takes the up to three results of one pixel
// input stalls only when the queue could not hold the results still in flight
// reset clears counters, window and queue; the line store needs no clearing pass
`include "pixel_neighbour_count_detector_assert.svh"

module pixel_neighbour_count_detector (
  input  logic                           clk,
  input  logic                           rst_n,
  pnc_pix_if.sink                        in_ch,
  pnc_res_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pnc_pkg::PADDR_W-1:0]    paddr,
  input  logic [pnc_pkg::DATA_W-1:0]     pwdata,
  output logic [pnc_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  logic [pnc_pkg::SIDE_W-1:0]  radar_width_r;
  logic [pnc_pkg::COLOR_W-1:0] class_a_r, class_b_r;
  logic [pnc_pkg::THR_W-1:0]   min_nb_r;
  pnc_pkg::reg_idx_t           reg_idx;
  logic                        cfg_wr;

  logic [pnc_pkg::SIDE_W-1:0] side;
  logic [pnc_pkg::COL_W-1:0]  side_m1;
  logic [pnc_pkg::COL_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic                       in_acc, cls, bottom, last_col;
  logic [pnc_pkg::COLOR_W-1:0] rgb;

  pnc_pkg::s1_t s1_r;
  logic         s1_valid_r;

  logic                      ls_we;
  logic [pnc_pkg::LS_AW-1:0] ls_waddr;
  logic [1:0]                ls_wdata, ls_rdata;
  pnc_pkg::push_t            push;
  logic                      head_valid, pop;
  pnc_pkg::res_t             head;
  logic [pnc_pkg::FIFO_AW:0] fifo_level;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = pnc_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radar_width_r <= pnc_pkg::RST_RADAR_WIDTH;
      class_a_r     <= pnc_pkg::RST_CLASS_A;
      class_b_r     <= pnc_pkg::RST_CLASS_B;
      min_nb_r      <= pnc_pkg::RST_MIN_NB;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        pnc_pkg::REG_RADAR_WIDTH: radar_width_r <= pwdata[pnc_pkg::SIDE_W-1:0];
        pnc_pkg::REG_CLASS_A:     class_a_r     <= pwdata[pnc_pkg::COLOR_W-1:0];
        pnc_pkg::REG_CLASS_B:     class_b_r     <= pwdata[pnc_pkg::COLOR_W-1:0];
        pnc_pkg::REG_MIN_NB:      min_nb_r      <= pwdata[pnc_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pnc_pkg::REG_RADAR_WIDTH: prdata = pnc_pkg::DATA_W'(radar_width_r);
      pnc_pkg::REG_CLASS_A:     prdata = pnc_pkg::DATA_W'(class_a_r);
      pnc_pkg::REG_CLASS_B:     prdata = pnc_pkg::DATA_W'(class_b_r);
      pnc_pkg::REG_MIN_NB:      prdata = pnc_pkg::DATA_W'(min_nb_r);
      default:                  prdata = '0;
    endcase
  end

  // frame side clamped to the supported range
  always_comb begin
    side = radar_width_r;
    if (radar_width_r < pnc_pkg::MIN_SIDE) begin
      side = pnc_pkg::MIN_SIDE;
    end else if (radar_width_r > pnc_pkg::MAX_SIDE) begin
      side = pnc_pkg::MAX_SIDE;
    end
  end
  assign side_m1 = pnc_pkg::COL_W'(side - pnc_pkg::SIDE_W'(1));

  // room for the worst case of the item in flight plus the new one
  assign in_ch.ready = ((pnc_pkg::FIFO_AW+1)'(fifo_level) +
                        (s1_valid_r ? (pnc_pkg::FIFO_AW+1)'(pnc_pkg::MAX_RES) : '0))
                       <= (pnc_pkg::FIFO_AW+1)'(pnc_pkg::FIFO_DEPTH - pnc_pkg::MAX_RES);
  assign in_acc = in_ch.valid && in_ch.ready;

  assign rgb      = {in_ch.red, in_ch.green, in_ch.blue};
  assign cls      = (rgb == class_a_r) || (rgb == class_b_r);
  assign bottom   = row_r >= side_m1;
  assign last_col = col_r >= side_m1;

  always_comb begin
    col_nxt = col_r + pnc_pkg::COL_W'(1);
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = bottom ? '0 : row_r + pnc_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= '{cls: cls, col: col_r, row: row_r, bottom: bottom, last_col: last_col};
    end
  end

  pnc_ram #(
    .WIDTH(2),
    .DEPTH(pnc_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .raddr (pnc_pkg::LS_AW'(col_r)),
    .rdata (ls_rdata)
  );

  pnc_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid_r),
    .s1       (s1_r),
    .ls_rdata (ls_rdata),
    .min_nb   (min_nb_r),
    .ls_we    (ls_we),
    .ls_waddr (ls_waddr),
    .ls_wdata (ls_wdata),
    .push     (push)
  );

  assign pop = head_valid && out_ch.ready;

  pnc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .level      (fifo_level)
  );

  assign out_ch.valid      = head_valid;
  assign out_ch.col        = head.col;
  assign out_ch.row        = head.row;
  assign out_ch.frame_end  = head.frame_end;
  assign out_ch.none_found = head.none_found;

  // write-back of the line store never meets a read of the same column
  `ASSERT_IMPLIES(a_rmw_distinct, clk, rst_n, s1_valid_r && in_acc, s1_r.col != col_r)
  `ASSERT_IMPLIES(a_fifo_bound, clk, rst_n, 1'b1,
                  fifo_level <= (pnc_pkg::FIFO_AW+1)'(pnc_pkg::FIFO_DEPTH))
  `ASSERT_NEXT(a_frame_wrap, clk, rst_n, in_acc && last_col && bottom,
               col_r == '0 && row_r == '0)

endmodule
